// File: src/kth_pkg.sv
package kth_pkg;

    localparam int TRACKS_DEF = 16;
    localparam int DEPTH_DEF  = 32;

    localparam int KEY_W   = 24;
    localparam int LAT_W   = 28;
    localparam int LON_W   = 29;
    localparam int TIME_W  = 32;
    localparam int STEP_W  = 48;
    localparam int CNT_W   = 7;
    localparam int POINT_W = LAT_W + LON_W;

    // Input payload: operation, key, lat, lon, now_ms; key_present rides in tuser.
    localparam int S_DATA_W = 120;
    // Output payload: status, found, point_lat, point_lon, point_count; last is tlast.
    localparam int M_DATA_W = 72;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 48;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_EXPIRE = 2'd1,
        OP_PATH   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_APPENDED   = 2'd0,
        ST_SUPPRESSED = 2'd1,
        ST_IGNORED    = 2'd2,
        ST_DONE       = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP_SQ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TTL_MS      = 1'd1;

    localparam logic [TIME_W-1:0] TTL_RESET = 32'd60000;

    // Result item handed from the sequencer to the output register.
    typedef struct packed {
        status_t           status;
        logic              found;
        logic [LAT_W-1:0]  lat;
        logic [LON_W-1:0]  lon;
        logic [CNT_W-1:0]  count;
        logic              last;
    } result_t;

endpackage

// File: src/kth_ram.sv
module kth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/kth_sqdist.sv
module kth_sqdist (
    input  logic                        aclk,
    input  logic                        start,
    input  logic [kth_pkg::LAT_W-1:0]   new_lat,
    input  logic [kth_pkg::LON_W-1:0]   new_lon,
    input  logic [kth_pkg::POINT_W-1:0] old_point,
    input  logic [kth_pkg::STEP_W-1:0]  min_step_sq,
    output logic                        too_close
);
    import kth_pkg::*;

    // Differences are at most 30 bits in magnitude; squares fit 60 bits.
    logic signed [LON_W:0] dla_c, dlo_c;
    logic [LON_W:0]        a_reg, b_reg;
    logic [2*LON_W+1:0]    sa_reg, sb_reg;
    logic [2*LON_W+2:0]    sum_c;

    assign dla_c = {{2{new_lat[LAT_W-1]}}, new_lat}
                 - {{2{old_point[LAT_W-1]}}, old_point[LAT_W-1:0]};
    assign dlo_c = {new_lon[LON_W-1], new_lon}
                 - {old_point[POINT_W-1], old_point[POINT_W-1:LAT_W]};
    assign sum_c = {1'b0, sa_reg} + {1'b0, sb_reg};

    // Stage one takes magnitudes, stage two squares, stage three compares.
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= dla_c[LON_W] ? (LON_W+1)'(0) - dla_c : dla_c;
            b_reg <= dlo_c[LON_W] ? (LON_W+1)'(0) - dlo_c : dlo_c;
        end
        sa_reg    <= a_reg * a_reg;
        sb_reg    <= b_reg * b_reg;
        too_close <= sum_c < {13'd0, min_step_sq};
    end

endmodule

// File: src/keyed_track_history_table.sv
// Keyed track history table.
// Requests enter on the s_axis channel: operation, key, lat, lon and now_ms
// in s_axis_tdata, key_present in s_axis_tuser. Results leave on m_axis with
// tlast on the final result of each request. Registers are written on the
// cfg channel (index 0 min_step_sq, index 1 ttl_ms); the user must write
// them only while the block is idle, as the block does not enforce it. One
// request is worked at a time; s_axis_tready is low until its last result
// has been taken. A sequencer walks the track slots one per cycle, scanning
// them all for every request with a key and for every expire or clear, then
// picks the slot. Record then reads the newest point and checks the step in
// the distance unit, through S_RD, S_WAIT1 to S_WAIT3 and S_COMMIT. Expire,
// clear, a path miss and a path to an empty track answer from S_WIPE. A path
// read passes S_PRD, S_PRD2 and S_EMIT for each point in turn. A record or
// path without a key answers from S_SCAN without scanning. A stalled
// receiver holds the result in the output register and the sequencer waits.
// After reset the table is empty, min_step_sq is 0 and ttl_ms is 60000; the
// point memory is not cleared, since no track reads a point it never wrote.
module keyed_track_history_table #(
    parameter int TRACKS = kth_pkg::TRACKS_DEF,
    parameter int DEPTH  = kth_pkg::DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // operation[1:0], key[25:2], lat[53:26], lon[82:54], now_ms[114:83], zeros
    input  logic [kth_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // key_present[0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // status[1:0], found[2], point_lat[30:3], point_lon[59:31], point_count[66:60]
    output logic [kth_pkg::M_DATA_W-1:0]   m_axis_tdata,
    output logic                           m_axis_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kth_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kth_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kth_pkg::*;

    localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int DW = $clog2(DEPTH);
    localparam int AW = TW + DW;
    localparam int MEM_DEPTH = 2 ** AW;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [DW-1:0] LAST_SLOT = DW'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CLAIM, S_RD, S_WAIT1, S_WAIT2, S_WAIT3, S_WAIT4,
        S_WAIT5, S_COMMIT, S_PRD, S_PRD2, S_EMIT, S_WIPE
    } state_t;

    state_t state_reg;

    // Per-track state, read at the sequencer's slot index; total and head also at the hit slot.
    logic [KEY_W-1:0]  key_reg   [TRACKS];
    logic              used_reg  [TRACKS];
    logic [CNT_W-1:0]  total_reg [TRACKS];
    logic [DW-1:0]     head_reg  [TRACKS];
    logic [TIME_W-1:0] seen_reg  [TRACKS];

    logic [STEP_W-1:0] min_step_reg;
    logic [TIME_W-1:0] ttl_reg;

    op_t               op_reg;
    logic [KEY_W-1:0]  rkey_reg;
    logic              present_reg;
    logic [LAT_W-1:0]  rlat_reg;
    logic [LON_W-1:0]  rlon_reg;
    logic [TIME_W-1:0] now_reg;

    logic [TW-1:0]     idx_reg;
    logic              hit_reg, free_reg;
    logic [TW-1:0]     hit_idx_reg, free_idx_reg, vic_idx_reg;
    logic [TIME_W-1:0] vic_seen_reg;
    logic [CNT_W-1:0]  n_reg, i_reg;
    logic [DW-1:0]     ptr_reg;

    result_t res_reg;
    logic    out_valid_reg;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [POINT_W-1:0] mem_rdata;
    logic              sq_start, too_close;

    logic [TIME_W-1:0] age_c;
    logic [DW-1:0]     prev_c, next_head_c;
    logic [CNT_W-1:0]  head_ext_c, start_c;
    logic              out_free;

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign age_c         = now_reg - seen_reg[idx_reg];

    // Ring slots wrap at DEPTH.
    assign prev_c      = (head_reg[idx_reg] == '0) ? LAST_SLOT : head_reg[idx_reg] - DW'(1);
    assign next_head_c = (head_reg[idx_reg] == LAST_SLOT) ? '0 : head_reg[idx_reg] + DW'(1);
    assign head_ext_c  = CNT_W'(head_reg[hit_idx_reg]);
    assign start_c     = (head_ext_c >= total_reg[hit_idx_reg])
                       ? head_ext_c - total_reg[hit_idx_reg]
                       : head_ext_c + DEPTH_C - total_reg[hit_idx_reg];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = res_reg.last;
    assign m_axis_tdata  = {5'd0, res_reg.count, res_reg.lon, res_reg.lat,
                            res_reg.found, res_reg.status};

    // Point memory addressing: track in the high bits, ring slot low.
    assign mem_we    = (state_reg == S_COMMIT) && out_free
                    && (total_reg[idx_reg] == '0 || !too_close);
    assign mem_waddr = {idx_reg, head_reg[idx_reg]};
    assign mem_raddr = (state_reg == S_RD) ? {idx_reg, prev_c} : {idx_reg, ptr_reg};
    assign sq_start  = (state_reg == S_WAIT1);

    kth_ram #(.WIDTH(POINT_W), .DEPTH(MEM_DEPTH)) u_points (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data ({rlon_reg, rlat_reg}),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    kth_sqdist u_sq (
        .aclk        (aclk),
        .start       (sq_start),
        .new_lat     (rlat_reg),
        .new_lon     (rlon_reg),
        .old_point   (mem_rdata),
        .min_step_sq (min_step_reg),
        .too_close   (too_close)
    );

    // Sequencer, table state and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            min_step_reg  <= '0;
            ttl_reg       <= TTL_RESET;
            for (int t = 0; t < TRACKS; t++) begin
                used_reg[t]  <= 1'b0;
                key_reg[t]   <= '0;
                total_reg[t] <= '0;
                head_reg[t]  <= '0;
                seen_reg[t]  <= '0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MIN_STEP_SQ: min_step_reg <= cfg_data;
                    REG_TTL_MS:      ttl_reg <= cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            // The result leaves; states that load a new one set the flag themselves.
            if (out_valid_reg && m_axis_tready
                    && !(state_reg inside {S_COMMIT, S_EMIT, S_WIPE})) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        op_reg      <= op_t'(s_axis_tdata[1:0]);
                        rkey_reg    <= s_axis_tdata[25:2];
                        rlat_reg    <= s_axis_tdata[53:26];
                        rlon_reg    <= s_axis_tdata[82:54];
                        now_reg     <= s_axis_tdata[114:83];
                        present_reg <= s_axis_tuser;
                        idx_reg     <= '0;
                        hit_reg     <= 1'b0;
                        free_reg    <= 1'b0;
                        vic_idx_reg <= '0;
                        vic_seen_reg <= seen_reg[0];
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!present_reg && (op_reg == OP_RECORD || op_reg == OP_PATH)) begin
                        res_reg <= '{ST_IGNORED, 1'b0, '0, '0, '0, 1'b1};
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        unique case (op_reg)
                            OP_EXPIRE: begin
                                if (used_reg[idx_reg] && age_c >= ttl_reg) begin
                                    used_reg[idx_reg]  <= 1'b0;
                                    key_reg[idx_reg]   <= '0;
                                    total_reg[idx_reg] <= '0;
                                    head_reg[idx_reg]  <= '0;
                                    seen_reg[idx_reg]  <= '0;
                                end
                            end
                            OP_CLEAR: begin
                                used_reg[idx_reg]  <= 1'b0;
                                key_reg[idx_reg]   <= '0;
                                total_reg[idx_reg] <= '0;
                                head_reg[idx_reg]  <= '0;
                                seen_reg[idx_reg]  <= '0;
                            end
                            default: begin
                                if (used_reg[idx_reg] && key_reg[idx_reg] == rkey_reg
                                        && !hit_reg) begin
                                    hit_reg     <= 1'b1;
                                    hit_idx_reg <= idx_reg;
                                end
                                if (!used_reg[idx_reg] && !free_reg) begin
                                    free_reg     <= 1'b1;
                                    free_idx_reg <= idx_reg;
                                end
                                if (seen_reg[idx_reg] < vic_seen_reg) begin
                                    vic_seen_reg <= seen_reg[idx_reg];
                                    vic_idx_reg  <= idx_reg;
                                end
                            end
                        endcase
                        if (idx_reg == TW'(TRACKS - 1)) begin
                            state_reg <= S_CLAIM;
                        end else begin
                            idx_reg <= idx_reg + TW'(1);
                        end
                    end
                end
                S_CLAIM: begin
                    unique case (op_reg)
                        OP_RECORD: begin
                            if (hit_reg) begin
                                idx_reg <= hit_idx_reg;
                            end else begin
                                idx_reg <= free_reg ? free_idx_reg : vic_idx_reg;
                                used_reg[free_reg ? free_idx_reg : vic_idx_reg]  <= 1'b1;
                                key_reg[free_reg ? free_idx_reg : vic_idx_reg]   <= rkey_reg;
                                total_reg[free_reg ? free_idx_reg : vic_idx_reg] <= '0;
                                head_reg[free_reg ? free_idx_reg : vic_idx_reg]  <= '0;
                            end
                            state_reg <= S_RD;
                        end
                        OP_PATH: begin
                            idx_reg <= hit_idx_reg;
                            if (!hit_reg || total_reg[hit_idx_reg] == '0) begin
                                state_reg <= S_WIPE;
                            end else begin
                                n_reg   <= total_reg[hit_idx_reg];
                                i_reg   <= '0;
                                ptr_reg <= start_c[DW-1:0];
                                state_reg <= S_PRD;
                            end
                        end
                        default: state_reg <= S_WIPE;
                    endcase
                end
                S_RD:    state_reg <= S_WAIT1;
                S_WAIT1: state_reg <= S_WAIT2;
                S_WAIT2: state_reg <= S_WAIT3;
                S_WAIT3: state_reg <= S_COMMIT;
                S_COMMIT: begin
                    if (out_free) begin
                        if (total_reg[idx_reg] != '0 && too_close) begin
                            res_reg <= '{ST_SUPPRESSED, 1'b0, '0, '0,
                                         total_reg[idx_reg], 1'b1};
                        end else begin
                            head_reg[idx_reg] <= next_head_c;
                            if (total_reg[idx_reg] < DEPTH_C) begin
                                total_reg[idx_reg] <= total_reg[idx_reg] + CNT_W'(1);
                            end
                            res_reg <= '{ST_APPENDED, 1'b0, '0, '0,
                                (total_reg[idx_reg] < DEPTH_C) ?
                                total_reg[idx_reg] + CNT_W'(1) : total_reg[idx_reg], 1'b1};
                        end
                        seen_reg[idx_reg] <= now_reg;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_PRD:  state_reg <= S_PRD2;
                S_PRD2: state_reg <= S_EMIT;
                S_EMIT: begin
                    if (out_free) begin
                        res_reg <= '{ST_DONE, 1'b1, mem_rdata[LAT_W-1:0],
                                     mem_rdata[POINT_W-1:LAT_W], n_reg,
                                     (i_reg + CNT_W'(1)) == n_reg};
                        out_valid_reg <= 1'b1;
                        i_reg   <= i_reg + CNT_W'(1);
                        ptr_reg <= (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + DW'(1);
                        state_reg <= ((i_reg + CNT_W'(1)) == n_reg) ? S_IDLE : S_PRD;
                    end
                end
                S_WIPE: begin
                    if (out_free) begin
                        res_reg <= '{ST_DONE, 1'b0, '0, '0, '0, 1'b1};
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted a request while busy");
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == ST_DONE)
        else $error("path point without done status");
`endif

endmodule

// File: sim/keyed_track_history_table_tb.sv
module keyed_track_history_table_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kth_pkg::*;

    localparam int NTRK = TRACKS_DEF;
    localparam int NPT  = DEPTH_DEF;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    keyed_track_history_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    typedef struct {
        status_t         status;
        bit              found;
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
        logic [CNT_W-1:0] count;
        bit              last;
    } track_result_t;

    track_result_t pending_results[$];
    int errors = 0;

    // Shadow copy of the table and its registers.
    logic [STEP_W-1:0]        min_step_sq = '0;
    logic [TIME_W-1:0]        ttl_ms = TTL_RESET;
    logic [KEY_W-1:0]         trk_key[NTRK];
    bit                       trk_used[NTRK];
    int                       trk_total[NTRK];
    int                       trk_head[NTRK];
    logic [TIME_W-1:0]        trk_seen[NTRK];
    logic signed [LAT_W-1:0]  pt_lat[NTRK][NPT];
    logic signed [LON_W-1:0]  pt_lon[NTRK][NPT];

    // Sender and receiver controls.
    bit no_gaps = 0;
    bit hold_request = 0;
    bit stalls_off = 0;

    function automatic void wipe_track(int t);
        trk_key[t] = '0;
        trk_used[t] = 0;
        trk_total[t] = 0;
        trk_head[t] = 0;
        trk_seen[t] = '0;
    endfunction

    function automatic void push_result(status_t st, bit fnd, logic [LAT_W-1:0] la,
                                        logic [LON_W-1:0] lo, int cnt, bit lst);
        track_result_t r;
        r.status = st;
        r.found = fnd;
        r.lat = la;
        r.lon = lo;
        r.count = cnt[CNT_W-1:0];
        r.last = lst;
        pending_results.push_back(r);
    endfunction

    function automatic int find_track(logic [KEY_W-1:0] k);
        for (int t = 0; t < NTRK; t++)
            if (trk_used[t] && trk_key[t] == k) return t;
        return -1;
    endfunction

    // Expected results of one accepted request.
    function automatic void predict_table(op_t op, logic [KEY_W-1:0] k, bit present,
                                          logic signed [LAT_W-1:0] la,
                                          logic signed [LON_W-1:0] lo,
                                          logic [TIME_W-1:0] now);
        int t, victim, n, first;
        longint dla, dlo;
        logic [63:0] step_sq;
        status_t st;
        case (op)
            OP_RECORD: begin
                if (!present) begin
                    push_result(ST_IGNORED, 0, '0, '0, 0, 1);
                    return;
                end
                t = find_track(k);
                if (t < 0) begin
                    // Claim the first free slot, else the one seen longest ago.
                    victim = 0;
                    t = -1;
                    for (int i = 0; i < NTRK; i++) begin
                        if (!trk_used[i]) begin
                            t = i;
                            break;
                        end
                        if (trk_seen[i] < trk_seen[victim]) victim = i;
                    end
                    if (t < 0) t = victim;
                    wipe_track(t);
                    trk_used[t] = 1;
                    trk_key[t] = k;
                end
                st = ST_APPENDED;
                if (trk_total[t] > 0) begin
                    first = (trk_head[t] + NPT - 1) % NPT;
                    dla = longint'(la) - longint'(pt_lat[t][first]);
                    dlo = longint'(lo) - longint'(pt_lon[t][first]);
                    if (dla < 0) dla = -dla;
                    if (dlo < 0) dlo = -dlo;
                    step_sq = 64'(dla * dla) + 64'(dlo * dlo);
                    if (step_sq < {16'd0, min_step_sq}) st = ST_SUPPRESSED;
                end
                if (st == ST_APPENDED) begin
                    pt_lat[t][trk_head[t]] = la;
                    pt_lon[t][trk_head[t]] = lo;
                    trk_head[t] = (trk_head[t] + 1) % NPT;
                    if (trk_total[t] < NPT) trk_total[t]++;
                end
                trk_seen[t] = now;
                push_result(st, 0, '0, '0, trk_total[t], 1);
            end
            OP_EXPIRE: begin
                for (int i = 0; i < NTRK; i++)
                    if (trk_used[i] && TIME_W'(now - trk_seen[i]) >= ttl_ms) wipe_track(i);
                push_result(ST_DONE, 0, '0, '0, 0, 1);
            end
            OP_PATH: begin
                if (!present) begin
                    push_result(ST_IGNORED, 0, '0, '0, 0, 1);
                    return;
                end
                t = find_track(k);
                if (t < 0 || trk_total[t] == 0) begin
                    push_result(ST_DONE, 0, '0, '0, 0, 1);
                    return;
                end
                n = trk_total[t];
                first = (trk_head[t] + NPT - n) % NPT;
                for (int i = 0; i < n; i++)
                    push_result(ST_DONE, 1, pt_lat[t][(first + i) % NPT],
                                pt_lon[t][(first + i) % NPT], n, i == n - 1);
            end
            default: begin
                for (int i = 0; i < NTRK; i++) wipe_track(i);
                push_result(ST_DONE, 0, '0, '0, 0, 1);
            end
        endcase
    endfunction

    // Offer one request; the valid stays up when the next one follows at once.
    task automatic send_request(op_t op, logic [KEY_W-1:0] k, bit present,
                                logic [LAT_W-1:0] la, logic [LON_W-1:0] lo,
                                logic [TIME_W-1:0] now);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= present;
        s_axis_tdata  <= {5'd0, now, lo, la, k, op};
        do @(posedge aclk); while (!s_axis_tready);
        predict_table(op, k, present, la, lo, now);
    endtask

    task automatic end_requests();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Register write, only with the table idle.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        end_requests();
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_MIN_STEP_SQ) min_step_sq = val;
        else ttl_ms = val[TIME_W-1:0];
        @(posedge aclk);
    endtask

    // Receiver: a random stall before each result, or a long hold on request.
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_request = 0;
            end
            stall = stalls_off ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    // Compare every result against the oldest expectation.
    always @(posedge aclk) begin
        track_result_t e;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_axis_tdata[1:0] != e.status) begin
                    $error("status: expected %0d, got %0d", e.status, m_axis_tdata[1:0]);
                    errors++;
                end
                if (m_axis_tdata[2] != e.found) begin
                    $error("found: expected %0d, got %0d", e.found, m_axis_tdata[2]);
                    errors++;
                end
                if (m_axis_tdata[30:3] != e.lat) begin
                    $error("point_lat: expected %h, got %h", e.lat, m_axis_tdata[30:3]);
                    errors++;
                end
                if (m_axis_tdata[59:31] != e.lon) begin
                    $error("point_lon: expected %h, got %h", e.lon, m_axis_tdata[59:31]);
                    errors++;
                end
                if (m_axis_tdata[66:60] != e.count) begin
                    $error("point_count: expected %0d, got %0d", e.count,
                           m_axis_tdata[66:60]);
                    errors++;
                end
                if (m_axis_tlast != e.last) begin
                    $error("last: expected %0d, got %0d", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Random coordinate close to a base point.
    function automatic logic [LAT_W-1:0] near_lat(logic signed [LAT_W-1:0] b);
        return b + LAT_W'($signed($urandom_range(0, 2000)) - 1000);
    endfunction

    function automatic logic [LON_W-1:0] near_lon(logic signed [LON_W-1:0] b);
        return b + LON_W'($signed($urandom_range(0, 2000)) - 1000);
    endfunction

    task automatic test_directed();
        // Missing key on record and path, path to an unknown track.
        send_request(OP_RECORD, 24'h123456, 0, '0, '0, 32'd5);
        send_request(OP_PATH, 24'h123456, 0, '0, '0, 32'd0);
        send_request(OP_PATH, 24'hABCDEF, 1, '0, '0, 32'd0);
        // Coordinate extremes, in range and at the raw field limits.
        send_request(OP_RECORD, 24'hFFFFFF, 1, -28'sd94371840, -29'sd188743680, 32'd10);
        send_request(OP_RECORD, 24'hFFFFFF, 1, 28'sd94371840, 29'sd188743680, 32'd20);
        send_request(OP_RECORD, 24'hFFFFFF, 1, 28'h8000000, 29'h10000000, 32'd30);
        send_request(OP_RECORD, 24'hFFFFFF, 1, 28'h7FFFFFF, 29'h0FFFFFFF, 32'd40);
        send_request(OP_RECORD, 24'h000000, 1, '0, '0, 32'hFFFFFFFF);
        send_request(OP_PATH, 24'hFFFFFF, 1, '0, '0, 32'd0);
        // Fill every slot, then evict the track seen longest ago.
        for (int i = 1; i < NTRK; i++)
            send_request(OP_RECORD, 24'(i * 24'h010101), 1, 28'(i), 29'(i), 32'(1000 + i));
        send_request(OP_RECORD, 24'h5A5A5A, 1, 28'd7, 29'd7, 32'd2000);
        send_request(OP_PATH, 24'hFFFFFF, 1, '0, '0, 32'd0);
        send_request(OP_EXPIRE, '0, 0, '0, '0, 32'd61010);
        send_request(OP_CLEAR, '0, 1, '0, '0, '0);
        send_request(OP_PATH, 24'h5A5A5A, 1, '0, '0, 32'd0);
    endtask

    task automatic test_threshold();
        // Close points get suppressed with a nonzero step threshold.
        write_register(REG_MIN_STEP_SQ, 48'd1000000);
        send_request(OP_RECORD, 24'h111111, 1, 28'd100, 29'd100, 32'd1);
        send_request(OP_RECORD, 24'h111111, 1, 28'd600, 29'd100, 32'd2);
        send_request(OP_RECORD, 24'h111111, 1, 28'd1600, 29'd100, 32'd3);
        send_request(OP_PATH, 24'h111111, 1, '0, '0, 32'd0);
        write_register(REG_MIN_STEP_SQ, 48'hFFFFFFFFFFFF);
        send_request(OP_RECORD, 24'h111111, 1, -28'sd94371840, 29'd0, 32'd4);
        send_request(OP_RECORD, 24'h111111, 1, 28'sd94371840, 29'h10000000, 32'd5);
        write_register(REG_MIN_STEP_SQ, 48'd0);
    endtask

    task automatic test_ttl();
        write_register(REG_TTL_MS, 32'd1);
        send_request(OP_RECORD, 24'h222222, 1, 28'd5, 29'd5, 32'hFFFFFFFF);
        send_request(OP_EXPIRE, '0, 0, '0, '0, 32'hFFFFFFFF);
        send_request(OP_EXPIRE, '0, 0, '0, '0, 32'd0);
        write_register(REG_TTL_MS, 32'hFFFFFFFF);
        send_request(OP_RECORD, 24'h333333, 1, 28'd5, 29'd5, 32'd10);
        send_request(OP_EXPIRE, '0, 0, '0, '0, 32'd9);
        send_request(OP_EXPIRE, '0, 0, '0, '0, 32'hFFFFFFFE);
        send_request(OP_PATH, 24'h333333, 1, '0, '0, 32'd0);
    endtask

    // Mostly position reports from a small fleet, with reads and housekeeping.
    task automatic test_random(int count);
        logic [KEY_W-1:0]         fleet[20];
        logic signed [LAT_W-1:0]  f_lat[20];
        logic signed [LON_W-1:0]  f_lon[20];
        logic [TIME_W-1:0]        clock_ms;
        int sel, kind;
        clock_ms = $urandom;
        for (int i = 0; i < 20; i++) begin
            fleet[i] = KEY_W'($urandom);
            f_lat[i] = LAT_W'($urandom);
            f_lon[i] = LON_W'($urandom);
        end
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 19);
            kind = $urandom_range(0, 99);
            clock_ms += $urandom_range(0, 3000);
            if (kind < 70) begin
                f_lat[sel] = near_lat(f_lat[sel]);
                f_lon[sel] = near_lon(f_lon[sel]);
                send_request(OP_RECORD, fleet[sel], 1, f_lat[sel], f_lon[sel], clock_ms);
            end else if (kind < 82) begin
                send_request(OP_PATH, fleet[sel], 1, '0, '0, $urandom);
            end else if (kind < 90) begin
                send_request(OP_EXPIRE, KEY_W'($urandom), 1'($urandom_range(0, 1)),
                             LAT_W'($urandom), LON_W'($urandom), clock_ms);
            end else if (kind < 92) begin
                send_request(OP_CLEAR, KEY_W'($urandom), 1'($urandom_range(0, 1)),
                             LAT_W'($urandom), LON_W'($urandom), $urandom);
            end else begin
                send_request(op_t'($urandom_range(0, 3)), KEY_W'($urandom),
                             1'($urandom_range(0, 1)), LAT_W'($urandom),
                             LON_W'($urandom), $urandom);
            end
        end
    endtask

    task automatic test_backpressure();
        // The receiver holds off while the sender keeps offering requests.
        no_gaps = 1;
        hold_request = 1;
        for (int i = 0; i < 6; i++)
            send_request(OP_RECORD, 24'h444444, 1, 28'(i * 5000), 29'(i * 7000), 32'(i));
        send_request(OP_PATH, 24'h444444, 1, '0, '0, 32'd0);
        no_gaps = 0;
        // The sender pauses until every result is back.
        end_requests();
        wait_drained();
        stalls_off = 1;
        send_request(OP_PATH, 24'h444444, 1, '0, '0, 32'd0);
        stalls_off = 0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        for (int t = 0; t < NTRK; t++) wipe_track(t);
        @(posedge aclk);
        test_directed();
        test_threshold();
        test_ttl();
        write_register(REG_TTL_MS, 32'd20000);
        write_register(REG_MIN_STEP_SQ, 48'd250000);
        test_random(35);
        write_register(REG_TTL_MS, TTL_RESET);
        write_register(REG_MIN_STEP_SQ, 48'd0);
        test_backpressure();
        test_random(35);
        end_requests();
        wait_drained();
        repeat (100) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #40ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
